// File: design/keypad_integer_calculator_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the keypad integer calculator
// Implication checks, clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef KEYPAD_INTEGER_CALCULATOR_UNIT_MACROS_SVH
`define KEYPAD_INTEGER_CALCULATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define KIC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("keypad calculator check failed");

// Next-cycle implication.
`define KIC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keypad calculator check failed");

`endif

// File: design/kic_pkg.sv
// ---------------------------------------------------------------------------
// Keypad integer calculator package
// Key codes, event codes, operation codes and the arithmetic unit interface.
// ---------------------------------------------------------------------------
package kic_pkg;

    // Key kinds.
    localparam logic [1:0] MODE_DIGIT  = 2'd0;
    localparam logic [1:0] MODE_OPER   = 2'd1;
    localparam logic [1:0] MODE_EQUALS = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // Event kinds reported with each result item.
    localparam logic [1:0] EV_CLEARED = 2'd0;
    localparam logic [1:0] EV_DIGIT   = 2'd1;
    localparam logic [1:0] EV_RESULT  = 2'd2;
    localparam logic [1:0] EV_DIVZERO = 2'd3;

    // Pending operation held between keys.
    localparam logic [2:0] PEND_NONE = 3'd0;
    localparam logic [2:0] PEND_ADD  = 3'd1;
    localparam logic [2:0] PEND_SUB  = 3'd2;
    localparam logic [2:0] PEND_MUL  = 3'd3;
    localparam logic [2:0] PEND_DIV  = 3'd4;
    localparam logic [2:0] PEND_DONE = 3'd5;

    // Decimal base of the entry accumulator.
    localparam logic [3:0] DIGIT_BASE = 4'd10;

    // Arithmetic unit operations.
    typedef logic [1:0] t_alu_op;
    localparam t_alu_op ALU_ADD = 2'd0;
    localparam t_alu_op ALU_MUL = 2'd1;
    localparam t_alu_op ALU_DIV = 2'd2;

    // Request from the key controller to the arithmetic unit.
    typedef struct packed {
        logic    start;
        t_alu_op op;
        logic    cin;
    } t_alu_req;

    // Status from the arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;

endpackage

// File: design/kic_alu.sv
// ---------------------------------------------------------------------------
// Keypad calculator arithmetic unit
// Iterative unit that retires one multiplier or quotient bit per cycle.
// ---------------------------------------------------------------------------
module kic_alu
    import kic_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_alu_req             i_req,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    input  logic [WORD_BITS-1:0] i_c,
    output t_alu_stat            o_stat,
    output logic [WORD_BITS-1:0] o_result
);

    localparam int CNT_W = $clog2(WORD_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DABS = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DFIX = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic [WORD_BITS-1:0] r_m, n_m;
    logic [WORD_BITS-1:0] r_q, n_q;
    logic [WORD_BITS-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_neg, n_neg;
    logic [WORD_BITS:0]   w_shifted;
    logic [WORD_BITS:0]   w_diff;

    // Restoring division trial subtraction.
    assign w_shifted = {r_rem, r_m[WORD_BITS-1]};
    assign w_diff    = w_shifted - {1'b0, r_q};

    // Sequencer for add, shift-and-add multiply and signed division.
    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_m     = r_m;
        n_q     = r_q;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        ALU_ADD: begin
                            n_acc   = i_a + i_b + {{(WORD_BITS-1){1'b0}}, i_req.cin};
                            n_state = S_DONE;
                        end
                        ALU_MUL: begin
                            n_acc   = i_c;
                            n_m     = i_a;
                            n_q     = i_b;
                            n_state = S_MUL;
                        end
                        ALU_DIV: begin
                            n_m     = i_a;
                            n_q     = i_b;
                            n_state = S_DABS;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                // Stop as soon as no multiplier bits remain.
                if (r_q == '0) begin
                    n_state = S_DONE;
                end else begin
                    if (r_q[0]) begin
                        n_acc = r_acc + r_m;
                    end
                    n_m = {r_m[WORD_BITS-2:0], 1'b0};
                    n_q = {1'b0, r_q[WORD_BITS-1:1]};
                end
            end
            S_DABS: begin
                // Take magnitudes and remember the quotient sign.
                n_neg   = r_m[WORD_BITS-1] ^ r_q[WORD_BITS-1];
                n_m     = r_m[WORD_BITS-1] ? (~r_m + 1'b1) : r_m;
                n_q     = r_q[WORD_BITS-1] ? (~r_q + 1'b1) : r_q;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // One quotient bit enters at the bottom of the dividend register.
                if (!w_diff[WORD_BITS]) begin
                    n_rem = w_diff[WORD_BITS-1:0];
                    n_m   = {r_m[WORD_BITS-2:0], 1'b1};
                end else begin
                    n_rem = w_shifted[WORD_BITS-1:0];
                    n_m   = {r_m[WORD_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_BITS - 1)) begin
                    n_state = S_DFIX;
                end
            end
            S_DFIX: begin
                n_acc   = r_neg ? (~r_m + 1'b1) : r_m;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_m   <= n_m;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_result    = r_acc;

endmodule

// File: design/keypad_integer_calculator_unit.sv
// ---------------------------------------------------------------------------
// Keypad integer calculator
// Four-function calculator driven by one key per input item.
// ---------------------------------------------------------------------------
// Each key gives exactly one result item. Operator and clear keys, and equals
// with no operation or with a zero divisor, do not start the arithmetic unit.
// A digit runs the shift-and-add pass that multiplies the entry by ten.
// Equals with add or subtract runs a single add; with multiply the multiplier
// loop retires one bit per cycle and stops once the entry has no bits left;
// with divide the unit retires one quotient bit per cycle plus sign handling.
// A new key is taken once the previous result has moved into the output
// register, so keys are accepted while a result waits to be taken.
module keypad_integer_calculator_unit
    import kic_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [3:0]         i_digit_value,
    input  logic [1:0]         i_op_code,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_event_kind,
    output logic signed [31:0] o_shown_value,
    output logic [3:0]         o_shown_digit,
    output logic               o_display_reset
);

`include "keypad_integer_calculator_unit_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [WORD_BITS-1:0] r_entry, n_entry;
    logic [WORD_BITS-1:0] r_first, n_first;
    logic [2:0]           r_pend, n_pend;
    logic                 r_dest_entry, n_dest_entry;
    logic                 r_out_valid, n_out_valid;

    logic [1:0]           r_res_kind, n_res_kind;
    logic [31:0]          r_res_value, n_res_value;
    logic [3:0]           r_res_digit, n_res_digit;
    logic                 r_res_dreset, n_res_dreset;

    logic [1:0]           r_out_kind, n_out_kind;
    logic [31:0]          r_out_value, n_out_value;
    logic [3:0]           r_out_digit, n_out_digit;
    logic                 r_out_dreset, n_out_dreset;

    t_alu_req             w_req;
    t_alu_stat            w_stat;
    logic [WORD_BITS-1:0] w_alu_a, w_alu_b, w_alu_c, w_alu_result;
    logic [WORD_BITS+31:0] w_first_ext, w_result_ext;
    logic                 w_accept;

    // Zero extension so that the low 32 bits exist at any word width.
    assign w_first_ext  = {32'd0, r_first};
    assign w_result_ext = {32'd0, w_alu_result};

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Arithmetic unit.
    kic_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .i_c      (w_alu_c),
        .o_stat   (w_stat),
        .o_result (w_alu_result)
    );

    // Key decoding, write-back of the arithmetic result and output loading.
    always_comb begin
        n_state      = r_state;
        n_entry      = r_entry;
        n_first      = r_first;
        n_pend       = r_pend;
        n_dest_entry = r_dest_entry;
        n_res_kind   = r_res_kind;
        n_res_value  = r_res_value;
        n_res_digit  = r_res_digit;
        n_res_dreset = r_res_dreset;
        n_out_kind   = r_out_kind;
        n_out_value  = r_out_value;
        n_out_digit  = r_out_digit;
        n_out_dreset = r_out_dreset;
        n_out_valid  = r_out_valid && !i_out_ready;
        w_req        = '0;
        w_alu_a      = '0;
        w_alu_b      = '0;
        w_alu_c      = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res_value  = '0;
                    n_res_digit  = '0;
                    n_res_dreset = 1'b0;
                    n_res_kind   = EV_CLEARED;
                    n_state      = ST_HOLD;
                    case (i_mode)
                        MODE_DIGIT: begin
                            // A digit after equals starts a fresh display.
                            if (r_pend == PEND_DONE) begin
                                n_res_dreset = 1'b1;
                                n_pend       = PEND_NONE;
                            end
                            n_res_kind   = EV_DIGIT;
                            n_res_digit  = i_digit_value;
                            n_dest_entry = 1'b1;
                            w_req.start  = 1'b1;
                            w_req.op     = ALU_MUL;
                            w_alu_a      = r_entry;
                            w_alu_b      = {{(WORD_BITS-4){1'b0}}, DIGIT_BASE};
                            w_alu_c      = {{(WORD_BITS-4){1'b0}}, i_digit_value};
                            n_state      = ST_BUSY;
                        end
                        MODE_OPER: begin
                            n_first = r_entry;
                            n_entry = '0;
                            n_pend  = {1'b0, i_op_code} + 3'd1;
                        end
                        MODE_EQUALS: begin
                            n_entry      = '0;
                            n_pend       = PEND_DONE;
                            n_res_kind   = EV_RESULT;
                            n_dest_entry = 1'b0;
                            w_alu_a      = r_first;
                            case (r_pend)
                                PEND_ADD: begin
                                    w_req.start = 1'b1;
                                    w_req.op    = ALU_ADD;
                                    w_alu_b     = r_entry;
                                    n_state     = ST_BUSY;
                                end
                                PEND_SUB: begin
                                    w_req.start = 1'b1;
                                    w_req.op    = ALU_ADD;
                                    w_req.cin   = 1'b1;
                                    w_alu_b     = ~r_entry;
                                    n_state     = ST_BUSY;
                                end
                                PEND_MUL: begin
                                    w_req.start = 1'b1;
                                    w_req.op    = ALU_MUL;
                                    w_alu_b     = r_entry;
                                    n_state     = ST_BUSY;
                                end
                                PEND_DIV: begin
                                    if (r_entry == '0) begin
                                        n_res_kind = EV_DIVZERO;
                                    end else begin
                                        w_req.start = 1'b1;
                                        w_req.op    = ALU_DIV;
                                        w_alu_b     = r_entry;
                                        n_state     = ST_BUSY;
                                    end
                                end
                                default: begin
                                    // No operation pending: show the first operand.
                                    n_res_value = w_first_ext[31:0];
                                end
                            endcase
                        end
                        default: begin
                            n_entry = '0;
                        end
                    endcase
                end
            end
            ST_BUSY: begin
                if (w_stat.done) begin
                    if (r_dest_entry) begin
                        n_entry = w_alu_result;
                    end else begin
                        n_res_value = w_result_ext[31:0];
                    end
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_kind   = r_res_kind;
                    n_out_value  = r_res_value;
                    n_out_digit  = r_res_digit;
                    n_out_dreset = r_res_dreset;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and calculator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_entry     <= '0;
            r_first     <= '0;
            r_pend      <= PEND_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_entry     <= n_entry;
            r_first     <= n_first;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_dest_entry <= n_dest_entry;
        r_res_kind   <= n_res_kind;
        r_res_value  <= n_res_value;
        r_res_digit  <= n_res_digit;
        r_res_dreset <= n_res_dreset;
        r_out_kind   <= n_out_kind;
        r_out_value  <= n_out_value;
        r_out_digit  <= n_out_digit;
        r_out_dreset <= n_out_dreset;
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_out_kind;
    assign o_shown_value   = r_out_value;
    assign o_shown_digit   = r_out_digit;
    assign o_display_reset = r_out_dreset;

    // The arithmetic unit is idle whenever a new key can be taken.
    `KIC_ASSERT_IMP(a_idle_alu, o_in_ready, !w_stat.busy)
    // A finished arithmetic operation always has a key waiting for it.
    `KIC_ASSERT_IMP(a_done_busy, w_stat.done, r_state == ST_BUSY)
    // Starting the unit moves the controller out of idle.
    `KIC_ASSERT_NXT(a_start_busy, w_req.start, r_state == ST_BUSY && w_stat.busy)

endmodule
